// File: design/c2fs_pkg.sv
package c2fs_pkg;

    localparam int COORD_WIDTH_DEF   = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    // Pre-scale puts the top magnitude bit at 2^57 whatever the coordinate width,
    // so the vectoring datapath width is fixed.
    localparam int PRESCALE_BASE = 58;
    localparam int DATA_W        = 61;
    localparam int ANG_W         = 32;
    localparam int ATAN_LEN      = 24;
    localparam int OUT_W         = 16;
    localparam int ANG_FRAC      = 15;

    localparam logic [OUT_W-1:0]        RHO_MAX   = 16'hFFFF;
    localparam logic [OUT_W-1:0]        ANG_MAX   = 16'h8000;
    localparam logic signed [ANG_W-1:0] ANG_HALF  = 32'sd536870912;
    localparam logic signed [ANG_W-1:0] ANG_RND   = 32'sd16384;

    typedef struct packed {
        logic signed [DATA_W-1:0] cx;
        logic signed [DATA_W-1:0] cy;
        logic signed [ANG_W-1:0]  z;
    } t_cordic_vec;

    // atan(2^-i)/pi in units of 2^-30
    function automatic logic signed [ANG_W-1:0] atan_coef(input logic [4:0] idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            5'd0:    v = 32'sd268435456;
            5'd1:    v = 32'sd158466703;
            5'd2:    v = 32'sd83729454;
            5'd3:    v = 32'sd42502378;
            5'd4:    v = 32'sd21333666;
            5'd5:    v = 32'sd10677233;
            5'd6:    v = 32'sd5339919;
            5'd7:    v = 32'sd2670123;
            5'd8:    v = 32'sd1335082;
            5'd9:    v = 32'sd667543;
            5'd10:   v = 32'sd333772;
            5'd11:   v = 32'sd166886;
            5'd12:   v = 32'sd83443;
            5'd13:   v = 32'sd41722;
            5'd14:   v = 32'sd20861;
            5'd15:   v = 32'sd10430;
            5'd16:   v = 32'sd5215;
            5'd17:   v = 32'sd2608;
            5'd18:   v = 32'sd1304;
            5'd19:   v = 32'sd652;
            5'd20:   v = 32'sd326;
            5'd21:   v = 32'sd163;
            5'd22:   v = 32'sd81;
            5'd23:   v = 32'sd41;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Round half up to Q1.15 and clamp to [0, 1].
    function automatic logic [OUT_W-1:0] angle_round(input logic signed [ANG_W-1:0] z);
        logic signed [ANG_W-1:0]  t;
        logic [ANG_W-ANG_FRAC-1:0] q;
        logic [OUT_W-1:0]          r;
        t = z + ANG_RND;
        q = t[ANG_W-1:ANG_FRAC];
        if (t[ANG_W-1]) begin
            r = '0;
        end else if (q > (ANG_W-ANG_FRAC)'(ANG_MAX)) begin
            r = ANG_MAX;
        end else begin
            r = q[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: design/cartesian_to_folded_spherical_unit.sv
// Cartesian to folded spherical converter. Each beat on the input carries one
// offset from the atlas centre (x, y, z, signed, 1/64 mm) and yields one beat
// on the output: rho = length / 128 mm in unsigned Q3.13 (equal to the length
// in 1/64 mm units, rounded, saturating at 65535), and phi = atan2(|x|, y)/pi
// and theta = atan2(|z|, y)/pi in unsigned Q1.15, folded so both lie in 0..1
// (atan2(0, 0) reads as 0; angles within 2 LSB). The datapath is a row of
// identical cells: two CORDIC vectoring chains for the angles and one
// digit-by-digit square-root chain for rho. A new beat may enter every cycle
// while the output is taken or some stage is empty. The beat passes through
// squaring, sum and fold set-up, the cell row and rounding. Each stage
// holds its own valid bit, so gaps in the stream are absorbed while the
// output waits.
module cartesian_to_folded_spherical_unit
    import c2fs_pkg::*;
#(
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [COORD_WIDTH-1:0] i_x_offset,
    input  logic [COORD_WIDTH-1:0] i_y_offset,
    input  logic [COORD_WIDTH-1:0] i_z_offset,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [OUT_W-1:0]       o_rho,
    output logic [OUT_W-1:0]       o_phi,
    output logic [OUT_W-1:0]       o_theta
);

    localparam int W        = COORD_WIDTH;
    localparam int PRESCALE = PRESCALE_BASE - COORD_WIDTH;
    localparam int L        = (COORD_WIDTH > CORDIC_STAGES) ? COORD_WIDTH : CORDIC_STAGES;
    localparam int NST      = L + 3;
    localparam int RW       = (W + 1 > OUT_W + 1) ? W + 1 : OUT_W + 1;

    // stage valids and per-stage advance
    logic [NST-1:0] r_v;
    logic [NST:0]   w_en;

    // stage 0: raw inputs and squares
    logic signed [W-1:0] r_x;
    logic signed [W-1:0] r_y;
    logic signed [W-1:0] r_z;
    logic [2*W-1:0]      r_px;
    logic [2*W-1:0]      r_py;
    logic [2*W-1:0]      r_pz;
    logic signed [2*W-1:0] w_sx;
    logic signed [2*W-1:0] w_sy;
    logic signed [2*W-1:0] w_sz;

    // stage 1: radicand and folded CORDIC start vectors
    logic [2*W-1:0] r_s;
    t_cordic_vec    r_cp;
    t_cordic_vec    r_ct;
    t_cordic_vec    n_cp;
    t_cordic_vec    n_ct;
    logic [W-1:0]   w_ax;
    logic [W-1:0]   w_az;
    logic [W-1:0]   w_ay;

    // cell row links
    t_cordic_vec    w_cp   [L+1];
    t_cordic_vec    w_ct   [L+1];
    logic [2*W-1:0] w_s    [L+1];
    logic [W+1:0]   w_rem  [L+1];
    logic [W-1:0]   w_root [L+1];

    // output stage
    logic [OUT_W-1:0] r_rho;
    logic [OUT_W-1:0] r_phi;
    logic [OUT_W-1:0] r_theta;
    logic [W:0]       w_rnd;
    logic [RW-1:0]    w_rnd_ext;
    logic [OUT_W-1:0] n_rho;

    // A stage may take a new beat when empty or when its contents move on.
    always_comb begin
        w_en[NST] = i_out_ready;
        for (int k = NST - 1; k >= 0; k--) begin
            w_en[k] = ~r_v[k] | w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_v[NST-1];

    // Stage 0: square the signed coordinates directly, the result is never negative.
    assign w_sx = (2*W)'($signed(i_x_offset)) * (2*W)'($signed(i_x_offset));
    assign w_sy = (2*W)'($signed(i_y_offset)) * (2*W)'($signed(i_y_offset));
    assign w_sz = (2*W)'($signed(i_z_offset)) * (2*W)'($signed(i_z_offset));

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_x  <= $signed(i_x_offset);
            r_y  <= $signed(i_y_offset);
            r_z  <= $signed(i_z_offset);
            r_px <= w_sx;
            r_py <= w_sy;
            r_pz <= w_sz;
        end
    end

    // Stage 1: sum the squares; fold each angle into the right half-plane.
    // With y negative, swap roles and start from a quarter turn.
    assign w_ax = r_x[W-1] ? W'(-r_x) : W'(r_x);
    assign w_az = r_z[W-1] ? W'(-r_z) : W'(r_z);
    assign w_ay = r_y[W-1] ? W'(-r_y) : W'(r_y);

    always_comb begin
        if (r_y[W-1]) begin
            n_cp.cx = DATA_W'(w_ax) << PRESCALE;
            n_cp.cy = DATA_W'(w_ay) << PRESCALE;
            n_cp.z  = ANG_HALF;
            n_ct.cx = DATA_W'(w_az) << PRESCALE;
            n_ct.cy = DATA_W'(w_ay) << PRESCALE;
            n_ct.z  = ANG_HALF;
        end else begin
            n_cp.cx = DATA_W'(w_ay) << PRESCALE;
            n_cp.cy = DATA_W'(w_ax) << PRESCALE;
            n_cp.z  = '0;
            n_ct.cx = DATA_W'(w_ay) << PRESCALE;
            n_ct.cy = DATA_W'(w_az) << PRESCALE;
            n_ct.z  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_s  <= r_px + r_py + r_pz;
            r_cp <= n_cp;
            r_ct <= n_ct;
        end
    end

    assign w_cp[0]   = r_cp;
    assign w_ct[0]   = r_ct;
    assign w_s[0]    = r_s;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;

    // Cell row: cells past the end of a chain just carry their beat along.
    for (genvar k = 0; k < L; k++) begin : g_cells
        c2fs_cordic_cell #(
            .IDX    (k),
            .ACTIVE (k < CORDIC_STAGES)
        ) u_phi (
            .i_clk (i_clk),
            .i_en  (w_en[k+2]),
            .i_d   (w_cp[k]),
            .o_q   (w_cp[k+1])
        );

        c2fs_cordic_cell #(
            .IDX    (k),
            .ACTIVE (k < CORDIC_STAGES)
        ) u_theta (
            .i_clk (i_clk),
            .i_en  (w_en[k+2]),
            .i_d   (w_ct[k]),
            .o_q   (w_ct[k+1])
        );

        c2fs_sqrt_cell #(
            .COORD_WIDTH (COORD_WIDTH),
            .ACTIVE      (k < COORD_WIDTH)
        ) u_sqrt (
            .i_clk  (i_clk),
            .i_en   (w_en[k+2]),
            .i_s    (w_s[k]),
            .i_rem  (w_rem[k]),
            .i_root (w_root[k]),
            .o_s    (w_s[k+1]),
            .o_rem  (w_rem[k+1]),
            .o_root (w_root[k+1])
        );
    end

    // Output stage: round the root to nearest (remainder above root means the
    // true root lies past the half), saturate, and round both angles.
    assign w_rnd     = (w_rem[L] > (W+2)'(w_root[L])) ? (W+1)'(w_root[L]) + (W+1)'(1)
                                                      : (W+1)'(w_root[L]);
    assign w_rnd_ext = RW'(w_rnd);
    assign n_rho     = (w_rnd_ext > RW'(RHO_MAX)) ? RHO_MAX : w_rnd_ext[OUT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_en[NST-1]) begin
            r_rho   <= n_rho;
            r_phi   <= angle_round(w_cp[L].z);
            r_theta <= angle_round(w_ct[L].z);
        end
    end

    assign o_rho   = r_rho;
    assign o_phi   = r_phi;
    assign o_theta = r_theta;

endmodule

// File: design/c2fs_cordic_cell.sv
module c2fs_cordic_cell
    import c2fs_pkg::*;
#(
    parameter int IDX    = 0,
    parameter bit ACTIVE = 1'b1
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  t_cordic_vec i_d,
    output t_cordic_vec o_q
);

    t_cordic_vec             r_q;
    t_cordic_vec             n_q;
    logic signed [DATA_W-1:0] w_dx;
    logic signed [DATA_W-1:0] w_dy;
    logic signed [ANG_W-1:0]  w_a;
    logic                     w_pos;

    always_comb begin
        w_dx  = i_d.cy >>> IDX;
        w_dy  = i_d.cx >>> IDX;
        w_a   = atan_coef(5'(IDX));
        w_pos = ~i_d.cy[DATA_W-1] & (|i_d.cy);
        n_q   = i_d;
        if (ACTIVE) begin
            // rotate towards the x axis: sign of y picks the direction
            if (w_pos) begin
                n_q.cx = i_d.cx + w_dx;
                n_q.cy = i_d.cy - w_dy;
                n_q.z  = i_d.z + w_a;
            end else begin
                n_q.cx = i_d.cx - w_dx;
                n_q.cy = i_d.cy + w_dy;
                n_q.z  = i_d.z - w_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

// File: design/c2fs_sqrt_cell.sv
module c2fs_sqrt_cell
    import c2fs_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter bit ACTIVE      = 1'b1
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [2*COORD_WIDTH-1:0] i_s,
    input  logic [COORD_WIDTH+1:0]   i_rem,
    input  logic [COORD_WIDTH-1:0]   i_root,
    output logic [2*COORD_WIDTH-1:0] o_s,
    output logic [COORD_WIDTH+1:0]   o_rem,
    output logic [COORD_WIDTH-1:0]   o_root
);

    localparam int W = COORD_WIDTH;

    logic [2*W-1:0] r_s;
    logic [W+1:0]   r_rem;
    logic [W-1:0]   r_root;
    logic [2*W-1:0] n_s;
    logic [W+1:0]   n_rem;
    logic [W-1:0]   n_root;
    logic [W+1:0]   w_acc;
    logic [W+1:0]   w_trial;

    always_comb begin
        w_acc   = {i_rem[W-1:0], i_s[2*W-1 -: 2]};
        w_trial = {i_root, 2'b01};
        n_s     = i_s;
        n_rem   = i_rem;
        n_root  = i_root;
        if (ACTIVE) begin
            // one result bit: bring down two radicand bits, try root*4+1
            n_s = {i_s[2*W-3:0], 2'b00};
            if (w_acc >= w_trial) begin
                n_rem  = w_acc - w_trial;
                n_root = {i_root[W-2:0], 1'b1};
            end else begin
                n_rem  = w_acc;
                n_root = {i_root[W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s    <= n_s;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_s    = r_s;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule
